// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a condition at every clock edge outside reset
`define ASSERT_NOW(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed");
// check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rst_n, cond)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/kcem_pkg.sv
// ----------------------------------------------------------------------------
// kcem_pkg
// Sizes and constants of the keyed cache with smallest-key eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package kcem_pkg;

	localparam int CAP    = 64;
	localparam int IDX_W  = $clog2(CAP);
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int LIM_W  = 7;
	localparam int CMP_W  = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam int KEY_W  = 64;
	localparam int VAL_W  = 32;
	localparam int ENT_W  = KEY_W + VAL_W;
	localparam int STAT_W = 32;
	localparam int REP_W  = 7;

	localparam logic [LIM_W-1:0] LIM_RST = 7'd64;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

endpackage

`default_nettype wire

// File: rtl/keyed_cache_evict_min_key.sv
// ----------------------------------------------------------------------------
// keyed_cache_evict_min_key
// Fully associative 64-bit key to 32-bit value cache, smallest key evicted.
// ----------------------------------------------------------------------------
// Timing: one transaction at a time. Every pass over the entries is a scan of
// the entry memory at one entry per cycle, bound by the read port. A lookup
// takes one pass and a result step. An insert takes one pass and an evict
// step per evicted entry plus one final pass and a result step, with up to
// CAP evictions when the limit drops to zero on a full cache. The input
// stalls while a transaction is in work; a finished result waits in the
// output register and does not stall input.
`default_nettype none

`include "assert_macros.svh"

module keyed_cache_evict_min_key (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [kcem_pkg::LIM_W-1:0]      cfg_wdata,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire                             cmd,
	input  wire  [kcem_pkg::KEY_W-1:0]      lookup_key,
	input  wire  [kcem_pkg::VAL_W-1:0]      new_value,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic                            found,
	output logic [kcem_pkg::VAL_W-1:0]      found_value,
	output logic [kcem_pkg::REP_W-1:0]      evictions,
	output logic [kcem_pkg::STAT_W-1:0]     hits_so_far,
	output logic [kcem_pkg::STAT_W-1:0]     misses_so_far,
	output logic [kcem_pkg::REP_W-1:0]      occupancy
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_EVICT  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	localparam logic MODE_FIND = 1'b0;
	localparam logic MODE_MIN  = 1'b1;

	localparam logic [kcem_pkg::CNT_W-1:0] SCAN_END = kcem_pkg::CNT_W'(kcem_pkg::CAP);
	localparam logic [kcem_pkg::IDX_W-1:0] IDX_LAST = kcem_pkg::IDX_W'(kcem_pkg::CAP - 1);

	// control state
	logic [2:0]                      state_q;
	logic                            mode_q;
	logic [kcem_pkg::LIM_W-1:0]      limit_q;
	logic [kcem_pkg::CAP-1:0]        valid_q;
	logic [kcem_pkg::CNT_W-1:0]      count_q;
	logic [kcem_pkg::STAT_W-1:0]     hit_q;
	logic [kcem_pkg::STAT_W-1:0]     miss_q;
	logic [kcem_pkg::CNT_W-1:0]      scan_q;
	logic                            vld_s1;
	logic                            out_vld_q;
	logic [kcem_pkg::REP_W-1:0]      evict_q;
	logic                            best_vld_q;
	logic                            match_q;
	logic                            free_vld_q;

	// payload
	logic                            cmd_q;
	logic [kcem_pkg::KEY_W-1:0]      key_q;
	logic [kcem_pkg::VAL_W-1:0]      val_q;
	logic [kcem_pkg::IDX_W-1:0]      idx_s1;
	logic [kcem_pkg::ENT_W-1:0]      rdata_s1;
	logic [kcem_pkg::KEY_W-1:0]      best_key_q;
	logic [kcem_pkg::IDX_W-1:0]      best_idx_q;
	logic [kcem_pkg::IDX_W-1:0]      match_idx_q;
	logic [kcem_pkg::VAL_W-1:0]      match_val_q;
	logic [kcem_pkg::IDX_W-1:0]      free_idx_q;

	logic                            found_q;
	logic [kcem_pkg::VAL_W-1:0]      found_val_q;
	logic [kcem_pkg::REP_W-1:0]      evict_out_q;
	logic [kcem_pkg::STAT_W-1:0]     hit_out_q;
	logic [kcem_pkg::STAT_W-1:0]     miss_out_q;
	logic [kcem_pkg::REP_W-1:0]      occ_out_q;

	logic [kcem_pkg::ENT_W-1:0]      ent_mem [kcem_pkg::CAP];

	logic                            accept;
	logic                            load;
	logic                            mem_re;
	logic [kcem_pkg::IDX_W-1:0]      raddr;
	logic                            mem_we;
	logic [kcem_pkg::IDX_W-1:0]      waddr;
	logic [kcem_pkg::CMP_W-1:0]      limit_eff;
	logic                            need_evict;
	logic                            ent_vld;
	logic [kcem_pkg::KEY_W-1:0]      rkey;
	logic [kcem_pkg::VAL_W-1:0]      rval;
	logic                            scan_last;
	logic                            is_ins;
	logic                            is_hit;
	logic [kcem_pkg::CNT_W-1:0]      count_nxt;
	logic [kcem_pkg::STAT_W-1:0]     hit_nxt;
	logic [kcem_pkg::STAT_W-1:0]     miss_nxt;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load     = (state_q == ST_DONE) && (!out_vld_q || !out_stall);

	assign limit_eff = (kcem_pkg::CMP_W'(limit_q) > kcem_pkg::CMP_W'(kcem_pkg::CAP)) ?
		kcem_pkg::CMP_W'(kcem_pkg::CAP) : kcem_pkg::CMP_W'(limit_q);
	assign need_evict = (cmd_q == kcem_pkg::CMD_INSERT) &&
		(kcem_pkg::CMP_W'(count_q) >= limit_eff) && (count_q != '0);

	assign mem_re    = (state_q == ST_SCAN) && (scan_q != SCAN_END);
	assign raddr     = scan_q[kcem_pkg::IDX_W-1:0];
	assign ent_vld   = valid_q[idx_s1];
	assign rkey      = rdata_s1[kcem_pkg::ENT_W-1:kcem_pkg::VAL_W];
	assign rval      = rdata_s1[kcem_pkg::VAL_W-1:0];
	assign scan_last = vld_s1 && (idx_s1 == IDX_LAST);

	assign is_ins = (cmd_q == kcem_pkg::CMD_INSERT);
	assign is_hit = !is_ins && match_q;
	assign mem_we = load && is_ins;
	assign waddr  = match_q ? match_idx_q : free_idx_q;

	assign count_nxt = (is_ins && !match_q) ? count_q + 1'b1 : count_q;
	assign hit_nxt   = is_hit ? hit_q + 1'b1 : hit_q;
	assign miss_nxt  = (!is_ins && !match_q) ? miss_q + 1'b1 : miss_q;

	// entry memory: key in the upper bits, value in the lower bits
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ent_mem[waddr] <= {key_q, val_q};
		end
		if (mem_re) begin
			rdata_s1 <= ent_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_FIND;
			limit_q    <= kcem_pkg::LIM_RST;
			valid_q    <= '0;
			count_q    <= '0;
			hit_q      <= '0;
			miss_q     <= '0;
			scan_q     <= '0;
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
			evict_q    <= '0;
			best_vld_q <= 1'b0;
			match_q    <= 1'b0;
			free_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			vld_s1 <= mem_re;
			if (mem_re) begin
				scan_q <= scan_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						evict_q <= '0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					mode_q     <= need_evict ? MODE_MIN : MODE_FIND;
					scan_q     <= '0;
					best_vld_q <= 1'b0;
					match_q    <= 1'b0;
					free_vld_q <= 1'b0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (vld_s1) begin
						if (mode_q == MODE_MIN) begin
							if (ent_vld && (!best_vld_q || rkey < best_key_q)) begin
								best_vld_q <= 1'b1;
							end
						end else begin
							if (ent_vld && rkey == key_q) begin
								match_q <= 1'b1;
							end
							if (!ent_vld) begin
								free_vld_q <= 1'b1;
							end
						end
					end
					if (scan_last) begin
						state_q <= (mode_q == MODE_MIN) ? ST_EVICT : ST_DONE;
					end
				end
				ST_EVICT: begin
					// drop the smallest key and check the limit again
					valid_q[best_idx_q] <= 1'b0;
					count_q             <= count_q - 1'b1;
					evict_q             <= evict_q + 1'b1;
					state_q             <= ST_DECIDE;
				end
				ST_DONE: begin
					if (load) begin
						if (is_ins) begin
							valid_q[waddr] <= 1'b1;
						end
						count_q   <= count_nxt;
						hit_q     <= hit_nxt;
						miss_q    <= miss_nxt;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// transaction payload, scan trackers and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= lookup_key;
			val_q <= new_value;
		end
		if (mem_re) begin
			idx_s1 <= raddr;
		end
		if (state_q == ST_SCAN && vld_s1) begin
			if (mode_q == MODE_MIN) begin
				if (ent_vld && (!best_vld_q || rkey < best_key_q)) begin
					best_key_q <= rkey;
					best_idx_q <= idx_s1;
				end
			end else begin
				if (ent_vld && rkey == key_q) begin
					match_idx_q <= idx_s1;
					match_val_q <= rval;
				end
				// keep the first free slot
				if (!ent_vld && !free_vld_q) begin
					free_idx_q <= idx_s1;
				end
			end
		end
		if (load) begin
			found_q     <= is_hit;
			found_val_q <= is_hit ? match_val_q : '0;
			evict_out_q <= is_ins ? evict_q : '0;
			hit_out_q   <= hit_nxt;
			miss_out_q  <= miss_nxt;
			occ_out_q   <= kcem_pkg::REP_W'(count_nxt);
		end
	end

	assign out_valid     = out_vld_q;
	assign found         = found_q;
	assign found_value   = found_val_q;
	assign evictions     = evict_out_q;
	assign hits_so_far   = hit_out_q;
	assign misses_so_far = miss_out_q;
	assign occupancy     = occ_out_q;

	`ASSERT_NOW(a_count_matches_valid, clk, arst_n, $countones(valid_q) == int'(count_q))
	`ASSERT_NOW(a_count_in_range, clk, arst_n, count_q <= SCAN_END)
	`ASSERT_IMPL(a_insert_has_slot, clk, arst_n, state_q == ST_DONE && is_ins && !match_q, free_vld_q)
	`ASSERT_IMPL(a_evict_has_victim, clk, arst_n, state_q == ST_EVICT, best_vld_q && valid_q[best_idx_q])

endmodule

`default_nettype wire

// File: dv/kcem_cache_checker.sv
// ----------------------------------------------------------------------------
// kcem_cache_checker
// Watches the item and result channels of the keyed cache, keeps its own
// copy of the entries, counters and entry limit, predicts one result per
// accepted item and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kcem_cache_checker
	import kcem_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [LIM_W-1:0]    cfg_wdata,
	input  wire                 in_valid,
	input  wire                 in_stall,
	input  wire                 cmd,
	input  wire  [KEY_W-1:0]    lookup_key,
	input  wire  [VAL_W-1:0]    new_value,
	input  wire                 out_valid,
	input  wire                 out_stall,
	input  wire                 found,
	input  wire  [VAL_W-1:0]    found_value,
	input  wire  [REP_W-1:0]    evictions,
	input  wire  [STAT_W-1:0]   hits_so_far,
	input  wire  [STAT_W-1:0]   misses_so_far,
	input  wire  [REP_W-1:0]    occupancy,
	output int                  fail_count,
	output int                  outstanding
);

	typedef struct packed {
		logic              found;
		logic [VAL_W-1:0]  found_value;
		logic [REP_W-1:0]  evictions;
		logic [STAT_W-1:0] hits;
		logic [STAT_W-1:0] misses;
		logic [REP_W-1:0]  occupancy;
	} cache_result_t;

	// shadow copy of the cache
	logic              slot_used [CAP];
	logic [KEY_W-1:0]  slot_key  [CAP];
	logic [VAL_W-1:0]  slot_val  [CAP];
	int                occupied   = 0;
	logic [STAT_W-1:0] hit_total  = '0;
	logic [STAT_W-1:0] miss_total = '0;
	logic [LIM_W-1:0]  limit_reg  = LIM_RST;

	cache_result_t expected_results[$];
	cache_result_t want;
	int            mismatches = 0;
	int            pending_n  = 0;

	assign fail_count  = mismatches;
	assign outstanding = pending_n;

	function automatic int find_slot(input logic [KEY_W-1:0] key);
		for (int i = 0; i < CAP; i++)
			if (slot_used[i] && slot_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic cache_result_t apply_item(input logic op, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] val);
		cache_result_t r;
		int            slot;
		int            best;
		int            eff_limit;
		int            evicted;
		r       = '0;
		evicted = 0;
		if (op == CMD_LOOKUP) begin
			slot = find_slot(key);
			if (slot >= 0) begin
				r.found       = 1'b1;
				r.found_value = slot_val[slot];
				hit_total++;
			end else begin
				miss_total++;
			end
		end else begin
			eff_limit = (limit_reg > CAP) ? CAP : int'(limit_reg);
			// drop smallest keys until under the limit or empty
			while (occupied >= eff_limit && occupied > 0) begin
				best = -1;
				for (int i = 0; i < CAP; i++)
					if (slot_used[i] && (best < 0 || slot_key[i] < slot_key[best]))
						best = i;
				slot_used[best] = 1'b0;
				occupied--;
				evicted++;
			end
			slot = find_slot(key);
			if (slot >= 0) begin
				slot_val[slot] = val;
			end else begin
				for (int i = 0; i < CAP; i++)
					if (!slot_used[i]) begin
						slot_used[i] = 1'b1;
						slot_key[i]  = key;
						slot_val[i]  = val;
						occupied++;
						break;
					end
			end
		end
		r.evictions = REP_W'(evicted);
		r.hits      = hit_total;
		r.misses    = miss_total;
		r.occupancy = REP_W'(occupied);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAP; i++)
				slot_used[i] = 1'b0;
			occupied   = 0;
			hit_total  = '0;
			miss_total = '0;
			limit_reg  = LIM_RST;
			expected_results.delete();
			pending_n  = 0;
		end else begin
			// retire the result first; an item taken on the same edge is younger
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transaction with nothing expected", $time);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("found", want.found, found);
					check_field("found_value", want.found_value, found_value);
					check_field("evictions", want.evictions, evictions);
					check_field("hits_so_far", want.hits, hits_so_far);
					check_field("misses_so_far", want.misses, misses_so_far);
					check_field("occupancy", want.occupancy, occupancy);
				end
			end
			if (cfg_we)
				limit_reg = cfg_wdata;
			if (in_valid && !in_stall)
				expected_results.push_back(apply_item(cmd, lookup_key, new_value));
			pending_n = expected_results.size();
		end
	end

endmodule

// File: dv/keyed_cache_evict_min_key_tb.sv
// ----------------------------------------------------------------------------
// keyed_cache_evict_min_key_tb
// Drives lookups and inserts into the keyed cache: a directed run over key
// extremes, duplicate inserts and limit corner values, then random phases
// over a small key pool at several entry limits and stall mixes. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyed_cache_evict_min_key_tb;
	import kcem_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int TAIL_CYCLES = 200;
	localparam int POOL_N      = 96;
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 334;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_we     = 1'b0;
	logic [LIM_W-1:0]  cfg_wdata  = '0;
	logic              in_valid   = 1'b0;
	logic              cmd        = CMD_LOOKUP;
	logic [KEY_W-1:0]  lookup_key = '0;
	logic [VAL_W-1:0]  new_value  = '0;
	logic              out_stall  = 1'b0;
	wire               in_stall;
	wire               out_valid;
	wire               found;
	wire  [VAL_W-1:0]  found_value;
	wire  [REP_W-1:0]  evictions;
	wire  [STAT_W-1:0] hits_so_far;
	wire  [STAT_W-1:0] misses_so_far;
	wire  [REP_W-1:0]  occupancy;
	int                fail_count;
	int                outstanding;

	int                send_idle_pct = 32;
	int                recv_idle_pct = 48;
	int                cycle_count   = 0;
	logic [KEY_W-1:0]  key_pool [POOL_N];
	logic [LIM_W-1:0]  phase_limit [N_PHASES] = '{7'd16, 7'd127, 7'd8, 7'd0, 7'd64, 7'd1};
	int                phase_span  [N_PHASES] = '{24, 96, 16, 8, 96, 4};

	keyed_cache_evict_min_key uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.lookup_key(lookup_key),
		.new_value(new_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.found_value(found_value),
		.evictions(evictions),
		.hits_so_far(hits_so_far),
		.misses_so_far(misses_so_far),
		.occupancy(occupancy)
	);

	kcem_cache_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.lookup_key(lookup_key),
		.new_value(new_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.found_value(found_value),
		.evictions(evictions),
		.hits_so_far(hits_so_far),
		.misses_so_far(misses_so_far),
		.occupancy(occupancy),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic drive_item(input logic op, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		lookup_key <= key;
		new_value  <= val;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// hold off new items until every pending result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_limit(input logic [LIM_W-1:0] lim);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input int span);
		logic [KEY_W-1:0] k;
		if ($urandom_range(0, 99) < 88)
			k = key_pool[$urandom_range(0, span - 1)];
		else
			k = {$urandom, $urandom};
		return k;
	endfunction

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 64'h8000_0000_0000_0000;
		key_pool[3] = 64'h7FFF_FFFF_FFFF_FFFF;
		key_pool[4] = 64'h0000_0000_0000_0001;
		key_pool[5] = 64'hFFFF_FFFF_0000_0000;
		// pair each random key with a neighbor one bit away
		for (int i = 6; i < POOL_N; i++)
			key_pool[i] = (i % 2 == 0) ? {$urandom, $urandom}
				: key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, hits, misses, overwrite at reset limit
		drive_item(CMD_LOOKUP, '0, '1);
		drive_item(CMD_INSERT, '0, '0);
		drive_item(CMD_INSERT, '1, '1);
		drive_item(CMD_LOOKUP, '0, '0);
		drive_item(CMD_LOOKUP, '1, '0);
		drive_item(CMD_INSERT, '1, 32'h5A5A_A5A5);
		drive_item(CMD_LOOKUP, '1, '0);
		drive_item(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000);
		drive_item(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
		drive_item(CMD_INSERT, 64'h0000_0001_0000_0000, 32'h0000_0001);
		drive_item(CMD_INSERT, 64'h0000_0000_FFFF_FFFF, 32'hFFFF_0000);
		drive_item(CMD_LOOKUP, 64'h0000_0000_FFFF_FFFE, '0);
		// limit lowered below occupancy: nothing goes until the next insert
		set_limit(7'd3);
		drive_item(CMD_LOOKUP, 64'h8000_0000_0000_0000, '0);
		drive_item(CMD_INSERT, 64'd5, 32'h0000_0005);
		// duplicate that is the smallest key: evicted, then stored again
		drive_item(CMD_INSERT, 64'd5, 32'h0000_0055);
		// duplicate that survives eviction: overwrite in place
		drive_item(CMD_INSERT, 64'h8000_0000_0000_0000, 32'hDEAD_BEEF);
		drive_item(CMD_LOOKUP, 64'h8000_0000_0000_0000, '0);
		drive_item(CMD_LOOKUP, 64'd5, '0);
		// zero limit empties the cache before the store
		set_limit(7'd0);
		drive_item(CMD_INSERT, 64'd42, 32'hCAFE_F00D);
		drive_item(CMD_LOOKUP, 64'd42, '0);
		// limit above capacity
		set_limit(7'd127);
		drive_item(CMD_INSERT, 64'hFFFF_FFFF_0000_0000, 32'h0F0F_F0F0);
		drive_item(CMD_LOOKUP, 64'hFFFF_FFFF_0000_0000, '0);

		phase_limit[2] = LIM_W'($urandom_range(2, 12));
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 32;
				recv_idle_pct = 48;
			end else if (ph < 4) begin
				send_idle_pct = 48;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_limit(phase_limit[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 199) == 0)
					drain();
				drive_item(logic'($urandom_range(0, 1)), pick_key(phase_span[ph]), $urandom);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/kcem_pkg.sv
rtl/keyed_cache_evict_min_key.sv
dv/kcem_cache_checker.sv
dv/keyed_cache_evict_min_key_tb.sv
